FILE: rtl/core/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg: shared constants and types for the gradient depth shader
// Derived widths, fixed-point constants and the sideband beat struct.
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int SHADE_MAX     = 255;

  localparam int DIST_W  = 17;
  localparam int SHADE_W = 8;

  // |da| scaled to units of 2^-(F+1): diff times 1 or 2
  localparam int ABS_W   = DIST_W + 1;
  localparam int SQ_W    = 2 * ABS_W;
  // S scaled by 2^ONE_POS
  localparam int ONE_POS = 2 * FRACTION_BITS + 2;
  localparam int T_W     = ((ONE_POS > SQ_W) ? ONE_POS : SQ_W) + 2;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << ONE_POS;

  // Q = floor(4 * M^2 * 2^ONE_POS / t), never above 4 * M^2
  localparam longint MAX_SQ = longint'(SHADE_MAX) * longint'(SHADE_MAX);
  localparam longint Q_MAX  = 4 * MAX_SQ;
  localparam int Q_W        = $clog2(Q_MAX + 1);
  localparam int DV_W       = T_W + Q_W;
  localparam logic [DV_W-1:0] DIVIDEND = DV_W'(MAX_SQ) << (ONE_POS + 2);

  localparam int ROOT_W = (Q_W + 1) / 2;

  // depth path compare width
  localparam int TOP_W = $clog2(SHADE_MAX + 1) + FRACTION_BITS;
  localparam int NS_W  = FRACTION_BITS + 9;
  localparam int MX_W  = (TOP_W > NS_W) ? TOP_W : NS_W;
  localparam int CMP_W = ((MX_W > DIST_W) ? MX_W : DIST_W) + 1;
  localparam logic [CMP_W-1:0] NO_SURFACE = CMP_W'(256) << FRACTION_BITS;
  localparam logic [CMP_W-1:0] SHADE_TOP  = CMP_W'(SHADE_MAX) << FRACTION_BITS;

  typedef struct packed {
    logic               no_surface;
    logic [SHADE_W-1:0] depth;
  } side_t;

endpackage

FILE: rtl/core/gds_front.sv
// ----------------------------------------------------------------------------
// gds_front: differences, squares and normal-length sum
// Three stages: abs diffs and depth shade, squares, sum into t = S * 2^(2F+2).
// ----------------------------------------------------------------------------
module gds_front import gds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DIST_W-1:0] center_i,
  input  logic [DIST_W-1:0] inline_first_i,
  input  logic [DIST_W-1:0] inline_second_i,
  input  logic [DIST_W-1:0] across_first_i,
  input  logic [DIST_W-1:0] across_second_i,
  input  logic              inline_two_i,
  input  logic              across_two_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [T_W-1:0]    t_o,
  output side_t             side_o
);

  localparam int N = 3;

  logic [N-1:0] v_q, v_in, en;

  assign v_in = {v_q[N-2:0], in_valid_i};

  for (genvar j = 0; j < N; j++) begin : g_en
    assign en[j] = !(out_stall_i && (&v_q[N-1:j]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~en) | (v_in & en);
    end
  end

  // stage 0
  logic [DIST_W-1:0] da, db;
  logic [ABS_W-1:0]  a_d, b_d, a_q, b_q;
  logic [CMP_W-1:0]  c_ext, dep_full;
  side_t             side0_d, side0_q;

  always_comb begin
    da = (inline_first_i >= inline_second_i) ? inline_first_i - inline_second_i
                                             : inline_second_i - inline_first_i;
    db = (across_first_i >= across_second_i) ? across_first_i - across_second_i
                                             : across_second_i - across_first_i;
    a_d = inline_two_i ? {1'b0, da} : {da, 1'b0};
    b_d = across_two_i ? {1'b0, db} : {db, 1'b0};
    c_ext    = CMP_W'(center_i);
    dep_full = SHADE_TOP - c_ext;
    side0_d.no_surface = (c_ext >= NO_SURFACE);
    if (side0_d.no_surface || (c_ext >= SHADE_TOP)) begin
      side0_d.depth = '0;
    end else begin
      side0_d.depth = SHADE_W'(dep_full >> FRACTION_BITS);
    end
  end

  // stage 1
  logic [SQ_W-1:0] asq_q, bsq_q;
  side_t           side1_q;

  // stage 2
  logic [T_W-1:0] t_q;
  side_t          side2_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q     <= a_d;
      b_q     <= b_d;
      side0_q <= side0_d;
    end
    if (en[1]) begin
      asq_q   <= SQ_W'(a_q) * SQ_W'(a_q);
      bsq_q   <= SQ_W'(b_q) * SQ_W'(b_q);
      side1_q <= side0_q;
    end
    if (en[2]) begin
      t_q     <= T_ONE + T_W'(asq_q) + T_W'(bsq_q);
      side2_q <= side1_q;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[N-1];
  assign t_o         = t_q;
  assign side_o      = side2_q;

  a_t_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[N-1] |-> (t_q >= T_ONE))
    else $error("normal length sum below one");

endmodule

FILE: rtl/core/gds_div.sv
// ----------------------------------------------------------------------------
// gds_div: pipelined restoring divider
// One quotient bit per stage: Q = floor(4 * M^2 * 2^(2F+2) / t).
// ----------------------------------------------------------------------------
module gds_div import gds_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [T_W-1:0] t_i,
  input  side_t          side_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [Q_W-1:0] q_o,
  output side_t          side_o
);

  localparam int N = Q_W;

  logic [N-1:0] v_q, v_in, en;

  assign v_in = {v_q[N-2:0], in_valid_i};

  for (genvar j = 0; j < N; j++) begin : g_en
    assign en[j] = !(out_stall_i && (&v_q[N-1:j]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~en) | (v_in & en);
    end
  end

  logic [DV_W-1:0] rem_in [N];
  logic [T_W-1:0]  t_in   [N];
  logic [Q_W-1:0]  q_in   [N];
  side_t           side_in [N];

  logic [DV_W-1:0] rem_q  [N-1];
  logic [T_W-1:0]  t_q    [N-1];
  logic [Q_W-1:0]  q_q    [N];
  side_t           side_q [N];

  assign rem_in[0]  = DIVIDEND;
  assign t_in[0]    = t_i;
  assign q_in[0]    = '0;
  assign side_in[0] = side_i;

  for (genvar j = 1; j < N; j++) begin : g_link
    assign rem_in[j]  = rem_q[j-1];
    assign t_in[j]    = t_q[j-1];
    assign q_in[j]    = q_q[j-1];
    assign side_in[j] = side_q[j-1];
  end

  for (genvar j = 0; j < N; j++) begin : g_stg
    localparam int K = N - 1 - j;
    logic [DV_W-1:0] dvs;
    logic [DV_W:0]   trial;
    logic            fits;

    assign dvs   = DV_W'(t_in[j]) << K;
    assign trial = {1'b0, rem_in[j]} - {1'b0, dvs};
    assign fits  = !trial[DV_W];

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        q_q[j]    <= q_in[j] | (fits ? (Q_W'(1) << K) : '0);
        side_q[j] <= side_in[j];
      end
    end

    if (j < N - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en[j]) begin
          rem_q[j] <= fits ? trial[DV_W-1:0] : rem_in[j];
          t_q[j]   <= t_in[j];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[N-1];
  assign q_o         = q_q[N-1];
  assign side_o      = side_q[N-1];

  a_q_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (q_o <= Q_W'(Q_MAX)))
    else $error("quotient above 4*M^2");

endmodule

FILE: rtl/core/gds_root.sv
// ----------------------------------------------------------------------------
// gds_root: pipelined integer square root and shade output stage
// One root bit per stage, then g = (isqrt(Q) + 1) / 2 into the output register.
// ----------------------------------------------------------------------------
module gds_root import gds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [Q_W-1:0]     q_i,
  input  side_t              side_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SHADE_W-1:0] gradient_o,
  output logic [SHADE_W-1:0] depth_o
);

  localparam int N  = ROOT_W + 1;
  localparam int SQ = 2 * ROOT_W;

  logic [N-1:0] v_q, v_in, en;

  assign v_in = {v_q[N-2:0], in_valid_i};

  for (genvar j = 0; j < N; j++) begin : g_en
    assign en[j] = !(out_stall_i && (&v_q[N-1:j]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~en) | (v_in & en);
    end
  end

  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic [Q_W-1:0]    qv_in   [ROOT_W];
  side_t             side_in [ROOT_W];

  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [Q_W-1:0]    qv_q   [ROOT_W-1];
  side_t             side_q [ROOT_W];

  assign root_in[0] = '0;
  assign qv_in[0]   = q_i;
  assign side_in[0] = side_i;

  for (genvar j = 1; j < ROOT_W; j++) begin : g_link
    assign root_in[j] = root_q[j-1];
    assign qv_in[j]   = qv_q[j-1];
    assign side_in[j] = side_q[j-1];
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stg
    localparam int K = ROOT_W - 1 - j;
    logic [ROOT_W-1:0] cand;
    logic [SQ-1:0]     cand_sq;
    logic              fits;

    assign cand    = root_in[j] | (ROOT_W'(1) << K);
    assign cand_sq = SQ'(cand) * SQ'(cand);
    assign fits    = (cand_sq <= SQ'(qv_in[j]));

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        root_q[j] <= fits ? cand : root_in[j];
        side_q[j] <= side_in[j];
      end
    end

    if (j < ROOT_W - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en[j]) begin
          qv_q[j] <= qv_in[j];
        end
      end
    end
  end

  // output stage: largest g with 2g-1 <= isqrt(Q)
  logic [ROOT_W:0]    g_sum;
  logic [SHADE_W-1:0] grad_d, grad_q, depth_q;

  always_comb begin
    g_sum = {1'b0, root_q[ROOT_W-1]} + (ROOT_W + 1)'(1);
    if (side_q[ROOT_W-1].no_surface) begin
      grad_d = '0;
    end else begin
      grad_d = SHADE_W'(g_sum[ROOT_W:1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[N-1]) begin
      grad_q  <= grad_d;
      depth_q <= side_q[ROOT_W-1].depth;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[N-1];
  assign gradient_o  = grad_q;
  assign depth_o     = depth_q;

endmodule

FILE: rtl/core/gradient_depth_shader.sv
// ----------------------------------------------------------------------------
// gradient_depth_shader: depth-map pixel shader, one pixel per beat
// Throughput: one beat per cycle while out_stall_i is low; every stage carries
//   its own valid bit, so bubbles collapse under output stall and no beat is
//   lost or repeated.
// Reset: rst_ni clears all valid bits asynchronously; payload registers are
//   not reset. No state beyond the pipeline.
// ----------------------------------------------------------------------------
module gradient_depth_shader import gds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [DIST_W-1:0]  center_distance_i,
  input  logic [DIST_W-1:0]  inline_first_i,
  input  logic [DIST_W-1:0]  inline_second_i,
  input  logic [DIST_W-1:0]  across_first_i,
  input  logic [DIST_W-1:0]  across_second_i,
  input  logic               inline_spacing_two_i,
  input  logic               across_spacing_two_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SHADE_W-1:0] gradient_shade_o,
  output logic [SHADE_W-1:0] depth_shade_o
);

  // Shade math:
  //   t = S * 2^(2F+2) = 2^(2F+2) + a^2 + b^2, with a, b the neighbor
  //   differences in units of 2^-(F+1) (doubled for one-sided spacing).
  //   (2g-1)^2 * t <= 4*M^2*2^(2F+2) holds exactly when
  //   (2g-1)^2 <= Q = floor(4*M^2*2^(2F+2) / t), so g = (isqrt(Q) + 1) / 2.
  //   Q never exceeds 4*M^2, which caps g at SHADE_MAX.

  logic  front_valid, front_stall;
  logic  [T_W-1:0] front_t;
  side_t front_side;

  logic  div_valid, div_stall;
  logic  [Q_W-1:0] div_q;
  side_t div_side;

  // front end: diffs, depth shade, squares, sum
  gds_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .center_i        (center_distance_i),
    .inline_first_i  (inline_first_i),
    .inline_second_i (inline_second_i),
    .across_first_i  (across_first_i),
    .across_second_i (across_second_i),
    .inline_two_i    (inline_spacing_two_i),
    .across_two_i    (across_spacing_two_i),
    .out_valid_o     (front_valid),
    .out_stall_i     (front_stall),
    .t_o             (front_t),
    .side_o          (front_side)
  );

  // one quotient bit per stage
  gds_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_stall_o  (front_stall),
    .t_i         (front_t),
    .side_i      (front_side),
    .out_valid_o (div_valid),
    .out_stall_i (div_stall),
    .q_o         (div_q),
    .side_o      (div_side)
  );

  // one root bit per stage, then the registered output beat
  gds_root u_root (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_stall_o  (div_stall),
    .q_i         (div_q),
    .side_i      (div_side),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .gradient_o  (gradient_shade_o),
    .depth_o     (depth_shade_o)
  );

  // with no downstream stall every stage advances, so input is never held off
  a_no_stall_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  // input is held off only when a finished beat waits at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with no waiting output beat");

endmodule

FILE: tb/gradient_depth_shader_test.sv
// ----------------------------------------------------------------------------
// gradient_depth_shader_test: self-checking bench for the depth-map shader
// A short table of hand-picked pixels, then about 1600 random pixels, most of
// them smooth surfaces with random slopes. Beats with no typed-in result are
// shaded by a behavioral model kept here, and every output beat is compared
// field by field in order. Both channels idle in random bursts; the receiver
// holds off once for a long stretch so the pipeline backs up into its input.
// ----------------------------------------------------------------------------
module gradient_depth_shader_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gds_pkg::DIST_W;
  import gds_pkg::SHADE_W;
  import gds_pkg::FRACTION_BITS;
  import gds_pkg::SHADE_MAX;

  localparam int unsigned DIST_MAX  = (1 << DIST_W) - 1;
  localparam int unsigned NO_SURF   = 256 << FRACTION_BITS;
  localparam int unsigned SHADE_TOP = SHADE_MAX << FRACTION_BITS;
  // S is held scaled by 2^LIFT so that it stays an integer
  localparam int          LIFT      = 2 * FRACTION_BITS + 2;
  localparam logic [127:0] BOUND    = 128'(SHADE_MAX * SHADE_MAX) << (LIFT + 2);

  localparam int RANDOM_PIXELS = 1580;
  localparam int CALM_TAIL     = 150;   // last beats sent with no idling
  localparam int HOLD_AFTER    = 400;   // beats accepted before the long hold
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 64;    // pipeline is 31 deep

  typedef struct packed {
    logic [SHADE_W-1:0] gradient;
    logic [SHADE_W-1:0] depth;
  } shades_t;

  typedef struct packed {
    logic [DIST_W-1:0] center;
    logic [DIST_W-1:0] left;    // in-line first
    logic [DIST_W-1:0] right;   // in-line second
    logic [DIST_W-1:0] up;      // previous line
    logic [DIST_W-1:0] down;    // next line
    logic              in_two;
    logic              ac_two;
    logic              known;   // want is typed in by hand
    shades_t           want;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [DIST_W-1:0] center_distance, inline_first, inline_second;
  logic [DIST_W-1:0] across_first, across_second;
  logic inline_spacing_two, across_spacing_two;
  logic out_valid;
  logic out_stall;
  logic [SHADE_W-1:0] gradient_shade;
  logic [SHADE_W-1:0] depth_shade;

  pixel_t  pixel_plan[$];
  shades_t pending_shades[$];
  pixel_t  directed_rows[21];
  int      errors    = 0;
  int      accepted  = 0;
  int      delivered = 0;
  bit      calm      = 1'b0;
  bit      sent_all  = 1'b0;

  gradient_depth_shader DUT (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .center_distance_i   (center_distance),
    .inline_first_i      (inline_first),
    .inline_second_i     (inline_second),
    .across_first_i      (across_first),
    .across_second_i     (across_second),
    .inline_spacing_two_i(inline_spacing_two),
    .across_spacing_two_i(across_spacing_two),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .gradient_shade_o    (gradient_shade),
    .depth_shade_o       (depth_shade)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shade of one pixel: depth from the center, gradient as the largest g with
  // (2g-1)^2 * S <= 4 * SHADE_MAX^2, S = 1 + (da/sa)^2 + (db/sb)^2 exactly.
  function automatic shades_t shade_pixel(pixel_t p);
    logic [127:0] a, b, t;
    int g;
    shades_t s;
    s = '0;
    if (p.center >= NO_SURF) return s;
    s.depth = (p.center >= SHADE_TOP) ? '0 :
              SHADE_W'((SHADE_TOP - p.center) >> FRACTION_BITS);
    // differences in units of 2^-(F+1): one-sided spacing doubles them
    a = 128'((p.left >= p.right) ? p.left - p.right : p.right - p.left);
    b = 128'((p.up >= p.down) ? p.up - p.down : p.down - p.up);
    if (!p.in_two) a = a << 1;
    if (!p.ac_two) b = b << 1;
    t = (128'(1) << LIFT) + a * a + b * b;
    g = SHADE_MAX;
    while (g > 0 && 128'(2 * g - 1) * 128'(2 * g - 1) * t > BOUND) g--;
    s.gradient = g[SHADE_W-1:0];
    return s;
  endfunction

  function automatic pixel_t row(int c, int l, int r, int u, int d, bit i2, bit a2);
    pixel_t p;
    p = '0;
    p.center = DIST_W'(c);
    p.left   = DIST_W'(l);
    p.right  = DIST_W'(r);
    p.up     = DIST_W'(u);
    p.down   = DIST_W'(d);
    p.in_two = i2;
    p.ac_two = a2;
    return p;
  endfunction

  function automatic pixel_t row_known(int c, int l, int r, int u, int d, bit i2,
                                       bit a2, int g, int dp);
    pixel_t p;
    p = row(c, l, r, u, d, i2, a2);
    p.known = 1'b1;
    p.want.gradient = SHADE_W'(g);
    p.want.depth    = SHADE_W'(dp);
    return p;
  endfunction

  function automatic logic [DIST_W-1:0] near_distance(logic [DIST_W-1:0] base,
                                                      int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(DIST_MAX)) v = int'(DIST_MAX);
    return DIST_W'(v);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int mode, spread;
    p = '0;
    mode = int'($urandom_range(0, 99));
    if (mode < 70) begin
      // smooth surface: neighbours scattered around the center
      p.center = DIST_W'($urandom_range(0, NO_SURF - 1));
      case ($urandom_range(0, 3))
        0: spread = 16;
        1: spread = 256;
        2: spread = 1024;
        default: spread = 16384;
      endcase
      p.left  = near_distance(p.center, spread);
      p.right = near_distance(p.center, spread);
      p.up    = near_distance(p.center, spread);
      p.down  = near_distance(p.center, spread);
      // image border: a missing neighbour is replaced by the center
      case ($urandom_range(0, 7))
        0: p.left  = p.center;
        1: p.right = p.center;
        2: p.up    = p.center;
        3: p.down  = p.center;
        default: ;
      endcase
    end else if (mode < 85) begin
      // far away or no surface, neighbours anywhere
      p.center = DIST_W'($urandom_range(SHADE_TOP, DIST_MAX));
      p.left   = DIST_W'($urandom_range(0, DIST_MAX));
      p.right  = DIST_W'($urandom_range(0, DIST_MAX));
      p.up     = DIST_W'($urandom_range(0, DIST_MAX));
      p.down   = DIST_W'($urandom_range(0, DIST_MAX));
    end else begin
      p.center = DIST_W'($urandom_range(0, DIST_MAX));
      p.left   = DIST_W'($urandom_range(0, DIST_MAX));
      p.right  = DIST_W'($urandom_range(0, DIST_MAX));
      p.up     = DIST_W'($urandom_range(0, DIST_MAX));
      p.down   = DIST_W'($urandom_range(0, DIST_MAX));
    end
    p.in_two = 1'($urandom_range(0, 1));
    p.ac_two = 1'($urandom_range(0, 1));
    return p;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    errors++;
    if (errors <= 40)
      $display("ERROR at %0t, result beat %0d, %s: expected %0d, got %0d",
               $time, delivered, what, want, got);
  endtask

  // Directed table, then the random part
  initial begin
    directed_rows = '{
      row_known(0, 0, 0, 0, 0, 0, 0, 255, 255),                  // flat, nearest
      row_known('h10000, 0, 0, 0, 0, 0, 0, 0, 0),                // no surface
      row_known('h1FFFF, 'h1FFFF, 0, 0, 'h1FFFF, 1, 1, 0, 0),    // no surface, max
      row_known('h0FFFF, 'h0FFFF, 'h0FFFF, 'h0FFFF, 'h0FFFF, 0, 0, 255, 0),
      row_known('h0FF00, 'h0FF00, 'h0FF00, 'h0FF00, 'h0FF00, 1, 1, 255, 0),
      row_known('h0FEFF, 'h0FEFF, 'h0FEFF, 'h0FEFF, 'h0FEFF, 0, 1, 255, 0),
      row_known('h0FE00, 'h0FE00, 'h0FE00, 'h0FE00, 'h0FE00, 1, 0, 255, 1),
      row_known('h000FF, 'h000FF, 'h000FF, 'h000FF, 'h000FF, 0, 0, 255, 254),
      row_known('h00100, 'h00100, 'h00100, 'h00100, 'h00100, 1, 1, 255, 254),
      row_known('h08000, 0, 'h1FFFF, 'h1FFFF, 0, 0, 0, 0, 127), // too steep
      row('h08000, 0, 'h1FFFF, 'h08000, 'h08000, 1, 0),          // barely shaded
      row('h04000, 'h10000, 'h0FF00, 'h04000, 'h04000, 1, 0),    // neighbour at 256.0
      row('h03000, 'h03100, 'h03000, 'h03000, 'h03000, 0, 0),    // 45 degrees in-line
      row('h03000, 'h03200, 'h03000, 'h03000, 'h03000, 1, 0),
      row('h05000, 'h05000, 'h05000, 'h05000, 'h05100, 0, 1),
      row('h05000, 'h05000, 'h05000, 'h05000, 'h05100, 0, 0),
      row('h07000, 'h07080, 'h06F80, 'h07040, 'h06FC0, 1, 1),
      row('h07000, 'h06F80, 'h07080, 'h06FC0, 'h07040, 0, 0),    // reversed order
      row('h0AAAA, 'h15555, 'h0AAAA, 'h15555, 'h0AAAA, 1, 0),
      row('h05555, 'h0AAAA, 'h15555, 'h1FFFF, 'h00000, 0, 1),
      row('h00001, 'h00001, 'h00000, 'h00000, 'h00001, 0, 0)     // tiny slope
    };
    foreach (directed_rows[k]) pixel_plan.push_back(directed_rows[k]);
    repeat (RANDOM_PIXELS) pixel_plan.push_back(random_pixel());
  end

  // Sender: offers the plan in order, idles only between beats
  initial begin
    pixel_t p;
    in_valid           = 1'b0;
    center_distance    = '0;
    inline_first       = '0;
    inline_second      = '0;
    across_first       = '0;
    across_second      = '0;
    inline_spacing_two = 1'b0;
    across_spacing_two = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    for (int k = 0; k < pixel_plan.size(); k++) begin
      p = pixel_plan[k];
      if (k >= pixel_plan.size() - CALM_TAIL) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      in_valid           <= 1'b1;
      center_distance    <= p.center;
      inline_first       <= p.left;
      inline_second      <= p.right;
      across_first       <= p.up;
      across_second      <= p.down;
      inline_spacing_two <= p.in_two;
      across_spacing_two <= p.ac_two;
      do @(posedge clk); while (in_stall);
      pending_shades.push_back(p.known ? p.want : shade_pixel(p));
      accepted++;
    end
    in_valid <= 1'b0;
    sent_all = 1'b1;
  end

  // Receiver: random stall bursts and free runs, one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && accepted >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 32)) @(posedge clk);
      end
    end
  end

  // Output checker: in-order compare against the oldest expectation
  always @(posedge clk) begin
    shades_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_shades.size() == 0) begin
        report_mismatch("unexpected beat, gradient", -1, int'(gradient_shade));
      end else begin
        want = pending_shades.pop_front();
        if (gradient_shade !== want.gradient)
          report_mismatch("gradient_shade", int'(want.gradient), int'(gradient_shade));
        if (depth_shade !== want.depth)
          report_mismatch("depth_shade", int'(want.depth), int'(depth_shade));
      end
      delivered++;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (sent_all);
    while (pending_shades.size() != 0) @(posedge clk);
    // any extra beat would show up within the pipeline depth
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_shades.size() != 0)
      report_mismatch("results missing", 0, pending_shades.size());
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d beats accepted, %0d delivered", accepted, delivered);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
